>>> sv/bam_pkg.sv
// bam_pkg: shared constants, types and helper functions for the
// border-adaptive 3x3 median filter. No dependencies.
`default_nettype none

package bam_pkg;

   // frame geometry
   localparam int MAX_WIDTH    = 1024;
   localparam int MAX_HEIGHT   = 1024;
   localparam int MIN_DIM      = 2;
   localparam int COL_W        = $clog2(MAX_WIDTH);
   localparam int ROW_W        = $clog2(MAX_HEIGHT);
   localparam int CFG_W        = 11;
   localparam int OUT_COL_W    = 10;
   localparam int PIX_W        = 8;
   localparam int CSR_IDX_W    = 2;
   localparam int WIDTH_RESET  = (1024 < MAX_WIDTH) ? 1024 : MAX_WIDTH;
   localparam int HEIGHT_RESET = 1024;

   // window geometry and ranking
   localparam int WIN_COLS = 3;
   localparam int WIN_ROWS = 3;
   localparam int WIN_N    = WIN_COLS * WIN_ROWS;
   localparam int RANK_W   = $clog2(WIN_N);
   localparam int TGT_W    = $clog2(WIN_N / 2 + 1);

   // result queue sizing: every item in flight may still push two results
   localparam int FIFO_DEPTH  = 16;
   localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
   localparam int PIPE_ITEMS  = 4;
   localparam int READY_LIMIT = FIFO_DEPTH - 2 * PIPE_ITEMS;

   typedef enum logic [0:0] {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1
   } csr_index_type;

   typedef logic [PIX_W-1:0] pixel_type;

   // window entry (col * WIN_ROWS + row), column 0 oldest, row 0 top
   typedef pixel_type [WIN_N-1:0] window_type;

   typedef logic [WIN_N-1:0][RANK_W-1:0] rank_vec_type;

   // one line memory word: rows r-2 and r-1 of a column
   typedef struct packed {
      pixel_type older;
      pixel_type newer;
   } line_pair_type;

   // describes the up to two medians taken from one window position
   typedef struct packed {
      logic             emit_a;
      logic             emit_b;
      logic [WIN_N-1:0] mask_a;
      logic [WIN_N-1:0] mask_b;
      logic [TGT_W-1:0] tgt_a;
      logic [TGT_W-1:0] tgt_b;
      logic [COL_W-1:0] col_a;
      logic [COL_W-1:0] col_b;
      logic [ROW_W-1:0] row;
      logic             last_b;
   } med_tag_type;

   typedef struct packed {
      pixel_type            median_value;
      logic [OUT_COL_W-1:0] out_column;
      logic [ROW_W-1:0]     out_row;
      logic                 frame_last;
   } result_type;

   // in-image window positions
   function automatic logic [WIN_N-1:0] build_mask(input logic skip_left,
                                                   input logic skip_top,
                                                   input logic skip_bottom);
      logic [WIN_N-1:0] m;
      for (int ci = 0; ci < WIN_COLS; ci++) begin
         for (int ri = 0; ri < WIN_ROWS; ri++) begin
            m[ci*WIN_ROWS+ri] = !(skip_left && ci == 0) && !(skip_top && ri == 0) &&
                                !(skip_bottom && ri == WIN_ROWS - 1);
         end
      end
      return m;
   endfunction

   // sorted index floor(n/2) of the masked window
   function automatic logic [TGT_W-1:0] median_target(input logic [WIN_N-1:0] mask);
      return TGT_W'($countones(mask) >> 1);
   endfunction

endpackage

`default_nettype wire

>>> sv/bam_line_ram.sv
// bam_line_ram: line memory holding the two previous rows, one word per column.
// Single write port, single read port, registered read data. Uses bam_pkg.
`default_nettype none

module bam_line_ram (
   input  wire                           clock,
   input  wire                           rd_en,
   input  wire  [bam_pkg::COL_W-1:0]     rd_addr,
   output bam_pkg::line_pair_type        rd_data,
   input  wire                           wr_en,
   input  wire  [bam_pkg::COL_W-1:0]     wr_addr,
   input  bam_pkg::line_pair_type        wr_data
);

   bam_pkg::line_pair_type line_mem [bam_pkg::MAX_WIDTH];
   bam_pkg::line_pair_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> sv/bam_median.sv
// bam_median: two-stage rank-select median of the 3x3 window under two masks.
// Stage one ranks every entry, stage two picks the entry at the target rank. Uses bam_pkg.
`default_nettype none

module bam_median (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      in_valid,
   input  bam_pkg::window_type      in_win,
   input  bam_pkg::med_tag_type     in_tag,
   output logic                     res_a_valid,
   output bam_pkg::result_type      res_a,
   output logic                     res_b_valid,
   output bam_pkg::result_type      res_b
);

   logic                  valid_ff, valid_in;
   bam_pkg::window_type   val_ff;
   bam_pkg::med_tag_type  tag_ff;
   bam_pkg::rank_vec_type rank_a_ff, rank_a_in;
   bam_pkg::rank_vec_type rank_b_ff, rank_b_in;

   // rank of each entry: entries that sort ahead of it, ties broken by position
   always_comb begin
      logic [bam_pkg::WIN_N-1:0] prec;
      for (int i = 0; i < bam_pkg::WIN_N; i++) begin
         for (int j = 0; j < bam_pkg::WIN_N; j++) begin
            prec[j] = (j != i) &&
                      ((in_win[j] < in_win[i]) || ((in_win[j] == in_win[i]) && (j < i)));
         end
         rank_a_in[i] = bam_pkg::RANK_W'($countones(prec & in_tag.mask_a));
         rank_b_in[i] = bam_pkg::RANK_W'($countones(prec & in_tag.mask_b));
      end
   end

   assign valid_in = in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff    <= in_win;
      tag_ff    <= in_tag;
      rank_a_ff <= rank_a_in;
      rank_b_ff <= rank_b_in;
   end

   // select the entry whose rank equals the target
   always_comb begin
      bam_pkg::pixel_type med_a;
      bam_pkg::pixel_type med_b;
      med_a = '0;
      med_b = '0;
      for (int i = 0; i < bam_pkg::WIN_N; i++) begin
         if (tag_ff.mask_a[i] && (rank_a_ff[i] == bam_pkg::RANK_W'(tag_ff.tgt_a))) begin
            med_a = med_a | val_ff[i];
         end
         if (tag_ff.mask_b[i] && (rank_b_ff[i] == bam_pkg::RANK_W'(tag_ff.tgt_b))) begin
            med_b = med_b | val_ff[i];
         end
      end
      res_a.median_value = med_a;
      res_a.out_column   = bam_pkg::OUT_COL_W'(tag_ff.col_a);
      res_a.out_row      = tag_ff.row;
      res_a.frame_last   = 1'b0;
      res_b.median_value = med_b;
      res_b.out_column   = bam_pkg::OUT_COL_W'(tag_ff.col_b);
      res_b.out_row      = tag_ff.row;
      res_b.frame_last   = tag_ff.last_b;
   end

   assign res_a_valid = valid_ff && tag_ff.emit_a;
   assign res_b_valid = valid_ff && tag_ff.emit_b;

endmodule

`default_nettype wire

>>> sv/bam_rsp_fifo.sv
// bam_rsp_fifo: result queue taking up to two results per clock, giving one.
// Flip-flop storage with write and read pointers. Uses bam_pkg.
`default_nettype none

module bam_rsp_fifo (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              push_a,
   input  bam_pkg::result_type              data_a,
   input  wire                              push_b,
   input  bam_pkg::result_type              data_b,
   input  wire                              pop,
   output logic                             out_valid,
   output bam_pkg::result_type              out_data,
   output logic [bam_pkg::FIFO_CNT_W-1:0]   count
);

   bam_pkg::result_type               fifo_mem [bam_pkg::FIFO_DEPTH];
   logic [bam_pkg::FIFO_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [bam_pkg::FIFO_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [bam_pkg::FIFO_CNT_W-1:0]    count_ff, count_in;
   logic [1:0]                        push_n;
   logic                              do_pop;
   bam_pkg::result_type               first_data;

   // compact the pushes: the earlier result goes first
   assign push_n     = {1'b0, push_a} + {1'b0, push_b};
   assign first_data = push_a ? data_a : data_b;
   assign do_pop     = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + bam_pkg::FIFO_PTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + bam_pkg::FIFO_PTR_W'(do_pop);
      count_in  = count_ff + bam_pkg::FIFO_CNT_W'(push_n) - bam_pkg::FIFO_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage writes
   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         fifo_mem[wr_ptr_ff] <= first_data;
      end
      if (push_n == 2'd2) begin
         fifo_mem[wr_ptr_ff + bam_pkg::FIFO_PTR_W'(1)] <= data_b;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = fifo_mem[rd_ptr_ff];
   assign count     = count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= bam_pkg::FIFO_DEPTH)
      else $error("result queue count above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      int'(push_n) <= bam_pkg::FIFO_DEPTH - int'(count_ff))
      else $error("result queue overflow");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (do_pop && push_n == 2'd0) |=> (count_ff == $past(count_ff) - bam_pkg::FIFO_CNT_W'(1)))
      else $error("result queue count did not drop on pop");
`endif

endmodule

`default_nettype wire

>>> sv/border_adaptive_median_3x3.sv
// Streaming 3x3 median filter over 8-bit pixels sent in row-major order. Each
// pixel transfer (req_opcode pixel) may return the median of the pixel one row up
// and one column left; the last column of a row returns a second result for the
// row end. Border windows hold only in-image neighbors (4 at corners, 6 on edges)
// and give the upper median for even counts. After the frame's last pixel, send
// image_width drain transfers to flush the final row; the last of its results has
// rsp_frame_last set. Pixels arriving while a drain is pending and drains with none
// pending are taken and dropped. A width or height write restarts the frame. The
// block takes one item per clock: the line memory is read once for each item and, for
// a pixel, written back at a different column, so consecutive items never stall each
// other. A result passes the stage-one, window and median registers into the 16-entry
// result queue and is offered on rsp once written. Results average at most one per
// clock; the request side stalls only while more than eight results wait in the queue
// or a csr write is offered. The line memory needs no clearing pass after reset.
// A csr write holds off requests and is taken once the first pipeline stage is empty.
`default_nettype none

module border_adaptive_median_3x3 (
   input  wire                                clock,
   input  wire                                reset,
   // request channel
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire                                req_opcode,
   input  wire  [bam_pkg::PIX_W-1:0]          req_pixel_value,
   // result channel
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [bam_pkg::PIX_W-1:0]          rsp_median_value,
   output logic [bam_pkg::OUT_COL_W-1:0]      rsp_out_column,
   output logic [bam_pkg::ROW_W-1:0]          rsp_out_row,
   output logic                               rsp_frame_last,
   // register write channel
   input  wire                                csr_valid,
   output logic                               csr_ready,
   input  wire  [bam_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire  [bam_pkg::CFG_W-1:0]          csr_wdata
);

   // configuration and position
   logic [bam_pkg::CFG_W-1:0]   width_ff, width_in;
   logic [bam_pkg::CFG_W-1:0]   height_ff, height_in;
   logic [bam_pkg::COL_W-1:0]   col_ff, col_in;
   logic [bam_pkg::ROW_W-1:0]   row_ff, row_in;
   logic                        pend_ff, pend_in;

   // stage one: line memory read in flight
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_pix_ff, s1_pix_in;
   bam_pkg::pixel_type          s1_px_ff;
   logic [bam_pkg::COL_W-1:0]   s1_addr_ff;
   bam_pkg::med_tag_type        s1_tag_ff, s1_tag_in;

   // stage two: window
   bam_pkg::window_type         win_ff, win_in;
   logic                        win_valid_ff, win_valid_in;
   bam_pkg::med_tag_type        win_tag_ff;

   logic                        req_fire, csr_fire, restart;
   logic                        pix_go, drn_go, go;
   logic                        col_wrap, row_wrap;
   logic                        rd_en, wr_en;
   bam_pkg::line_pair_type      rd_data, wr_data;

   logic                        res_a_valid, res_b_valid;
   bam_pkg::result_type         res_a, res_b, out_data;
   logic [bam_pkg::FIFO_CNT_W-1:0] fifo_count;

   // handshakes
   assign req_ready = (int'(fifo_count) <= bam_pkg::READY_LIMIT) && !csr_valid;
   assign csr_ready = !s1_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign csr_fire  = csr_valid && csr_ready;
   assign restart   = csr_fire && ((csr_index == bam_pkg::CSR_WIDTH) ||
                                   (csr_index == bam_pkg::CSR_HEIGHT));

   assign pix_go = req_fire && (req_opcode == bam_pkg::OP_PIXEL) && !pend_ff;
   assign drn_go = req_fire && (req_opcode == bam_pkg::OP_DRAIN) && pend_ff;
   assign go     = pix_go || drn_go;

   assign col_wrap = (int'(col_ff) + 1) >= int'(width_ff);
   assign row_wrap = (int'(row_ff) + 1) >= int'(height_ff);

   // register writes with clamping
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_fire && (csr_index == bam_pkg::CSR_WIDTH)) begin
         if (int'(csr_wdata) < bam_pkg::MIN_DIM) begin
            width_in = bam_pkg::CFG_W'(bam_pkg::MIN_DIM);
         end else if (int'(csr_wdata) > bam_pkg::MAX_WIDTH) begin
            width_in = bam_pkg::CFG_W'(bam_pkg::MAX_WIDTH);
         end else begin
            width_in = csr_wdata;
         end
      end
      if (csr_fire && (csr_index == bam_pkg::CSR_HEIGHT)) begin
         if (int'(csr_wdata) < bam_pkg::MIN_DIM) begin
            height_in = bam_pkg::CFG_W'(bam_pkg::MIN_DIM);
         end else if (int'(csr_wdata) > bam_pkg::MAX_HEIGHT) begin
            height_in = bam_pkg::CFG_W'(bam_pkg::MAX_HEIGHT);
         end else begin
            height_in = csr_wdata;
         end
      end
   end

   // position counters; the column counter also counts drain transfers
   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      pend_in = pend_ff;
      if (restart) begin
         col_in  = '0;
         row_in  = '0;
         pend_in = 1'b0;
      end else if (pix_go) begin
         if (col_wrap) begin
            col_in = '0;
            if (row_wrap) begin
               pend_in = 1'b1;
            end else begin
               row_in = row_ff + bam_pkg::ROW_W'(1);
            end
         end else begin
            col_in = col_ff + bam_pkg::COL_W'(1);
         end
      end else if (drn_go) begin
         if (col_wrap) begin
            col_in  = '0;
            row_in  = '0;
            pend_in = 1'b0;
         end else begin
            col_in = col_ff + bam_pkg::COL_W'(1);
         end
      end
   end

   // result descriptors for the window this item completes
   always_comb begin
      logic skip_top;
      logic skip_left;
      logic row_ok;
      row_ok    = pix_go ? (row_ff != '0) : 1'b1;
      skip_top  = pix_go ? (row_ff < bam_pkg::ROW_W'(2)) : (row_ff == '0);
      skip_left = (col_ff < bam_pkg::COL_W'(2));
      s1_tag_in.emit_a = row_ok && (col_ff != '0);
      s1_tag_in.emit_b = row_ok && col_wrap;
      s1_tag_in.mask_a = bam_pkg::build_mask(skip_left, skip_top, drn_go);
      s1_tag_in.mask_b = bam_pkg::build_mask(1'b1, skip_top, drn_go);
      s1_tag_in.tgt_a  = bam_pkg::median_target(s1_tag_in.mask_a);
      s1_tag_in.tgt_b  = bam_pkg::median_target(s1_tag_in.mask_b);
      s1_tag_in.col_a  = col_ff - bam_pkg::COL_W'(1);
      s1_tag_in.col_b  = col_ff;
      s1_tag_in.row    = pix_go ? (row_ff - bam_pkg::ROW_W'(1)) : row_ff;
      s1_tag_in.last_b = drn_go;
   end

   assign s1_valid_in = go;
   assign s1_pix_in   = pix_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= bam_pkg::CFG_W'(bam_pkg::WIDTH_RESET);
         height_ff    <= bam_pkg::CFG_W'(bam_pkg::HEIGHT_RESET);
         col_ff       <= '0;
         row_ff       <= '0;
         pend_ff      <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s1_pix_ff    <= 1'b0;
         win_valid_ff <= 1'b0;
      end else begin
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pend_ff      <= pend_in;
         s1_valid_ff  <= s1_valid_in;
         s1_pix_ff    <= s1_pix_in;
         win_valid_ff <= win_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_px_ff   <= req_pixel_value;
      s1_addr_ff <= col_ff;
      s1_tag_ff  <= s1_tag_in;
      win_ff     <= win_in;
      win_tag_ff <= s1_tag_ff;
   end

   // line memory: read at accept, rotate rows and write back on the next clock
   assign rd_en         = go;
   assign wr_en         = s1_valid_ff && s1_pix_ff;
   assign wr_data.older = rd_data.newer;
   assign wr_data.newer = s1_px_ff;

   bam_line_ram u_line_ram (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (col_ff),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data)
   );

   // window shift: new column enters at the right, bottom row zero on drain
   always_comb begin
      win_in = win_ff;
      if (s1_valid_ff) begin
         for (int i = 0; i < bam_pkg::WIN_N - bam_pkg::WIN_ROWS; i++) begin
            win_in[i] = win_ff[i+bam_pkg::WIN_ROWS];
         end
         win_in[bam_pkg::WIN_N-3] = rd_data.older;
         win_in[bam_pkg::WIN_N-2] = rd_data.newer;
         win_in[bam_pkg::WIN_N-1] = s1_pix_ff ? s1_px_ff : '0;
      end
   end

   assign win_valid_in = s1_valid_ff && (s1_tag_ff.emit_a || s1_tag_ff.emit_b);

   bam_median u_median (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (win_valid_ff),
      .in_win      (win_ff),
      .in_tag      (win_tag_ff),
      .res_a_valid (res_a_valid),
      .res_a       (res_a),
      .res_b_valid (res_b_valid),
      .res_b       (res_b)
   );

   bam_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_a    (res_a_valid),
      .data_a    (res_a),
      .push_b    (res_b_valid),
      .data_b    (res_b),
      .pop       (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (out_data),
      .count     (fifo_count)
   );

   assign rsp_median_value = out_data.median_value;
   assign rsp_out_column   = out_data.out_column;
   assign rsp_out_row      = out_data.out_row;
   assign rsp_frame_last   = out_data.frame_last;

`ifndef SYNTHESIS
   a_no_same_entry: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en && (col_ff == s1_addr_ff)))
      else $error("line memory read and write hit the same column");

   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      int'(col_ff) < int'(width_ff))
      else $error("column counter beyond image width");

   a_drain_last_row: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (int'(row_ff) + 1 == int'(height_ff)))
      else $error("drain pending away from the last row");
`endif

endmodule

`default_nettype wire
